[sv/lru_key_value_cache_assert.svh]
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTH
`define LKVC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define LKVC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LKVC_ASSERT(lbl, clk, rstn, prop, msg)
`define LKVC_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/lkvc_pkg.sv]
package lkvc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_W           = 5;
  localparam int DATA_W          = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              touch;       // hit: matched entry becomes most recent
    logic              write_data;  // hit on a set: overwrite value
    logic              age_insert;  // insert: every valid entry ages by one
    logic              evict;       // insert: drop the oldest entry
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

  // per-cell status back to the controller
  typedef struct packed {
    logic              match;
    logic              valid;
    logic              claim;
    logic [DATA_W-1:0] data;
  } cell_stat_t;

endpackage

[sv/lkvc_cell.sv]
module lkvc_cell #(
  parameter int RankW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkvc_pkg::cell_cmd_t    cmd_i,
  input  logic [RankW-1:0]       touch_rank_i,
  input  logic [RankW-1:0]       evict_rank_i,
  input  logic                   tok_i,
  output logic                   tok_o,
  output lkvc_pkg::cell_stat_t   stat_o,
  output logic [RankW-1:0]       rank_o
);

  logic                        valid_q, valid_d;
  logic                        tok_q;
  logic [lkvc_pkg::DATA_W-1:0] key_q, key_d;
  logic [lkvc_pkg::DATA_W-1:0] data_q, data_d;
  logic [RankW-1:0]            rank_q, rank_d;
  logic                        match;
  logic                        claim;

  assign match = valid_q && (key_q == cmd_i.key);
  assign claim = tok_q && !valid_q;
  // token moves on past occupied slots
  assign tok_o = tok_q && valid_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    rank_d  = rank_q;
    if (cmd_i.touch) begin
      if (match) begin
        rank_d = '0;
        if (cmd_i.write_data) begin
          data_d = cmd_i.data;
        end
      end else if (valid_q && (rank_q < touch_rank_i)) begin
        rank_d = rank_q + RankW'(1);
      end
    end
    if (cmd_i.age_insert && valid_q) begin
      if (cmd_i.evict && (rank_q == evict_rank_i)) begin
        valid_d = 1'b0;
      end else begin
        rank_d = rank_q + RankW'(1);
      end
    end
    if (claim) begin
      valid_d = 1'b1;
      key_d   = cmd_i.key;
      data_d  = cmd_i.data;
      rank_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
    rank_q <= rank_d;
  end

  assign stat_o.match = match;
  assign stat_o.valid = valid_q;
  assign stat_o.claim = claim;
  assign stat_o.data  = data_q;
  assign rank_o       = rank_q;

endmodule

[sv/lru_key_value_cache.sv]
// Fully associative LRU key-value cache built as a row of entry cells.
//
// Input channel (in_valid_i / in_stall_o): one transaction is a get
// (mode_i = 0) or a set (mode_i = 1) with lookup_key_i and store_value_i.
// Output channel (out_valid_o / out_stall_i): each get yields one
// transaction, hit_o and read_value_o (stored value, or all ones on a miss).
// A set yields nothing.
// Config channel (cfg_valid_i / cfg_ready_o): writes capacity_in_use, always
// ready; write it only while the cache is idle. Zero acts as one, values
// above MAX_ENTRIES act as MAX_ENTRIES.
//
// Flow: a set on a present key goes from S_LOOK straight back to S_IDLE;
// a get passes S_LOOK and then waits in S_RESP until the output register
// is free, and loads it. A set on a new key walks a free-slot token
// down the cell row, one cell per cycle, in S_WALK until a free cell takes
// it. The row walk is what bounds the insert rate.
// A stalled result stays in the output register; the next request is still
// accepted, and only a second get waits for the output to drain.
// Reset clears every valid bit, the entry count and the output valid flag;
// capacity returns to 16.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] store_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0]         cfg_data_i
);

`include "lru_key_value_cache_assert.svh"

  localparam int RW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_WALK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [lkvc_pkg::CAP_W-1:0]  cap_q;
  logic [CW-1:0]               count_q, count_d;

  // captured request
  logic                        req_mode_q;
  logic [lkvc_pkg::DATA_W-1:0] req_key_q;
  logic [lkvc_pkg::DATA_W-1:0] req_data_q;

  // pending get result, then the output register
  logic                        res_hit_q, res_hit_d;
  logic [lkvc_pkg::DATA_W-1:0] res_value_q, res_value_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;
  logic                        out_hit_q;
  logic [lkvc_pkg::DATA_W-1:0] out_value_q;

  lkvc_pkg::cell_cmd_t         cmd;
  lkvc_pkg::cell_stat_t        stat    [MAX_ENTRIES];
  logic [RW-1:0]               rank    [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]        tok_chain;
  logic                        tok_in;
  logic [MAX_ENTRIES-1:0]      match_vec;
  logic [MAX_ENTRIES-1:0]      valid_vec;
  logic [MAX_ENTRIES-1:0]      claim_vec;

  logic                        hit;
  logic [lkvc_pkg::DATA_W-1:0] hit_data;
  logic [RW-1:0]               hit_rank;
  logic [RW-1:0]               evict_rank;
  logic [CMP_W-1:0]            cap_eff;
  logic                        need_evict;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // --- cell row ----------------------------------------------------------
  assign tok_chain[0] = tok_in;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .RankW (RW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .touch_rank_i (hit_rank),
      .evict_rank_i (evict_rank),
      .tok_i        (tok_chain[i]),
      .tok_o        (tok_chain[i+1]),
      .stat_o       (stat[i]),
      .rank_o       (rank[i])
    );
    assign match_vec[i] = stat[i].match;
    assign valid_vec[i] = stat[i].valid;
    assign claim_vec[i] = stat[i].claim;
  end

  // keys are unique, so at most one cell matches: plain OR mux
  always_comb begin
    hit_data = '0;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_data = hit_data | (stat[i].match ? stat[i].data : '0);
      hit_rank = hit_rank | (stat[i].match ? rank[i] : '0);
    end
  end

  assign hit        = |match_vec;
  // ranks of valid entries are always 0 .. count-1; oldest is count-1
  assign evict_rank = RW'(count_q - CW'(1));

  always_comb begin
    cap_eff = CMP_W'(cap_q);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end
  end

  assign need_evict = (CMP_W'(count_q) >= cap_eff);
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  // --- control -----------------------------------------------------------
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    res_hit_d       = res_hit_q;
    res_value_d     = res_value_q;
    tok_in          = 1'b0;
    cmd.touch       = 1'b0;
    cmd.write_data  = 1'b0;
    cmd.age_insert  = 1'b0;
    cmd.evict       = 1'b0;
    cmd.key         = req_key_q;
    cmd.data        = req_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        res_hit_d   = hit;
        res_value_d = hit ? hit_data : '1;
        if (hit) begin
          cmd.touch      = 1'b1;
          cmd.write_data = (req_mode_q == lkvc_pkg::MODE_SET);
          state_d        = (req_mode_q == lkvc_pkg::MODE_SET) ? S_IDLE : S_RESP;
        end else if (req_mode_q == lkvc_pkg::MODE_SET) begin
          cmd.age_insert = 1'b1;
          cmd.evict      = need_evict;
          tok_in         = 1'b1;
          count_d        = count_q - CW'(need_evict);
          state_d        = S_WALK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_WALK: begin
        if (|claim_vec) begin
          count_d = count_q + CW'(1);
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= lkvc_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_mode_q <= mode_i;
      req_key_q  <= lookup_key_i;
      req_data_q <= store_value_i;
    end
    res_hit_q   <= res_hit_d;
    res_value_q <= res_value_d;
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_value_q <= res_value_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_value_q;

  // --- checks ------------------------------------------------------------
  `LKVC_ASSERT(a_match_unique, clk_i, rst_ni, $onehot0(match_vec), "two cells hold one key")
  `LKVC_ASSERT(a_count_tracks, clk_i, rst_ni, $countones(valid_vec) == int'(count_q),
               "entry count differs from valid cells")
  `LKVC_NEVER(a_tok_overrun, clk_i, rst_ni, tok_chain[MAX_ENTRIES], "token left the cell row")
  `LKVC_ASSERT(a_walk_room, clk_i, rst_ni,
               (state_q == S_WALK) |-> (int'(count_q) < MAX_ENTRIES), "insert with no free cell")
  `LKVC_ASSERT(a_claim_once, clk_i, rst_ni, $onehot0(claim_vec), "several cells took the token")

endmodule

[bench/lru_key_value_cache_tb.sv]
// Self-checking bench for lru_key_value_cache.
// A shadow LRU store is updated on every accepted request and queues the
// expected get response; the monitor compares each returned transaction
// against the oldest queued one.
module lru_key_value_cache_tb;

  localparam int NUM_ENTRIES   = lkvc_pkg::MAX_ENTRIES_DEF;
  // margin for the worst insert, which walks the whole row
  localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int POOL_SIZE     = 32;

  typedef struct packed {
    logic                        mode;
    logic [lkvc_pkg::DATA_W-1:0] key;
    logic [lkvc_pkg::DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] value;
  } lookup_t;

  // DUT pins; the driven inputs are known from time zero
  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_stall_o;
  logic                               mode_i        = lkvc_pkg::MODE_GET;
  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key_i  = '0;
  logic signed [lkvc_pkg::DATA_W-1:0] store_value_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i   = 1'b0;
  logic                               hit_o;
  logic signed [lkvc_pkg::DATA_W-1:0] read_value_o;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [lkvc_pkg::CAP_W-1:0]         cfg_data_i    = '0;

  // stimulus and scoreboard
  request_t     requests_to_send [$];
  lookup_t      lookups_due [$];
  request_t     drive_req;
  lookup_t      want;
  logic         req_taken      = 1'b0;
  int           send_idle_pct  = 37;
  int           recv_stall_pct = 37;
  int           mismatches     = 0;
  logic [lkvc_pkg::DATA_W-1:0] key_pool [POOL_SIZE];

  // long receiver hold-off: toggle handshake so only the receiver owns its counter
  logic         hold_req    = 1'b0;
  logic         hold_ack    = 1'b0;
  int           hold_left   = 0;

  // shadow copy of the cache
  logic                        shadow_valid [NUM_ENTRIES] = '{default: 1'b0};
  logic [lkvc_pkg::DATA_W-1:0] shadow_key   [NUM_ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] shadow_data  [NUM_ENTRIES];
  int unsigned                 shadow_rank  [NUM_ENTRIES];  // 0 = most recent
  int unsigned                 shadow_count = 0;
  logic [lkvc_pkg::CAP_W-1:0]  shadow_cap   = lkvc_pkg::CAP_RESET;

  lru_key_value_cache dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .lookup_key_i (lookup_key_i),
    .store_value_i(store_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shadow LRU store
  // ---------------------------------------------------------------------
  function automatic int find_slot(logic [lkvc_pkg::DATA_W-1:0] key);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    return -1;
  endfunction

  // make slot most recent; anything newer than it ages by one
  function automatic void promote_slot(int idx);
    int unsigned r;
    r = shadow_rank[idx];
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[idx] = 0;
  endfunction

  function automatic void insert_entry(logic [lkvc_pkg::DATA_W-1:0] key,
                                       logic [lkvc_pkg::DATA_W-1:0] value);
    int unsigned limit;
    limit = shadow_cap;
    if (limit == 0) limit = 1;                      // zero acts as one
    if (limit > NUM_ENTRIES) limit = NUM_ENTRIES;   // clamp to the array
    // only one eviction, even when the capacity was lowered below the count
    if (shadow_count >= limit && shadow_count != 0) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_rank[i] == shadow_count - 1) begin
          shadow_valid[i] = 1'b0;
          shadow_count--;
          break;
        end
      end
    end
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_valid[i]) shadow_rank[i]++;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!shadow_valid[i]) begin
        shadow_valid[i] = 1'b1;
        shadow_key[i]   = key;
        shadow_data[i]  = value;
        shadow_rank[i]  = 0;
        shadow_count++;
        break;
      end
    end
  endfunction

  // apply one accepted request; a get queues its expected response
  function automatic void shadow_cache_access(request_t req);
    int      idx;
    lookup_t rsp;
    idx = find_slot(req.key);
    if (req.mode == lkvc_pkg::MODE_SET) begin
      if (idx >= 0) begin
        shadow_data[idx] = req.value;
        promote_slot(idx);
      end else begin
        insert_entry(req.key, req.value);
      end
    end else begin
      if (idx >= 0) begin
        promote_slot(idx);
        rsp.hit   = 1'b1;
        rsp.value = shadow_data[idx];
      end else begin
        rsp.hit   = 1'b0;
        rsp.value = '1;                             // miss reads back -1
      end
      lookups_due.push_back(rsp);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: new transaction only after the last one was taken
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req      = requests_to_send.pop_front();
        in_valid_i    <= 1'b1;
        mode_i        <= drive_req.mode;
        lookup_key_i  <= drive_req.key;
        store_value_i <= drive_req.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response side stall: random, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check responses first, then predict from this edge's request
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && !in_stall_o;
      if (cfg_valid_i && cfg_ready_o) shadow_cap = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        if (lookups_due.size() == 0) begin
          $error("unexpected response: hit=%0b read_value=%0d", hit_o, read_value_o);
          mismatches++;
        end else begin
          want = lookups_due.pop_front();
          if (hit_o !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit_o);
            mismatches++;
          end
          if (read_value_o !== want.value) begin
            $error("read_value: expected %0d, actual %0d", $signed(want.value),
                   read_value_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        shadow_cache_access(request_t'{mode: mode_i, key: lookup_key_i,
                                       value: store_value_i});
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void send(logic mode, logic [lkvc_pkg::DATA_W-1:0] key,
                               logic [lkvc_pkg::DATA_W-1:0] value);
    requests_to_send.push_back(request_t'{mode: mode, key: key, value: value});
  endfunction

  function automatic void refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
  endfunction

  // mostly keys from a small pool so gets hit and sets collide; some noise keys
  function automatic void send_random(int count, int pool_n);
    logic [lkvc_pkg::DATA_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
      send(($urandom_range(1) == 0) ? lkvc_pkg::MODE_GET : lkvc_pkg::MODE_SET, key,
           $urandom);
    end
  endfunction

  // everything sent, every response back, then let a pending insert walk finish
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (requests_to_send.size() != 0 || in_valid_i || lookups_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int cap;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity; key and value extremes, miss on empty, update in place.
    send(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
    send(lkvc_pkg::MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send(lkvc_pkg::MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send(lkvc_pkg::MODE_SET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(lkvc_pkg::MODE_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h5555_5555);
    send(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'hAAAA_AAAA);
    send(lkvc_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000);   // miss
    send(lkvc_pkg::MODE_SET, 32'hFFFF_FFFF, 32'h0000_0005);   // overwrite present key
    send(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < 13; i++) send(lkvc_pkg::MODE_SET, 32'h100 + i, 32'h1000 + i);
    send(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'h0);           // oldest key evicted by now
    send(lkvc_pkg::MODE_GET, 32'h100, 32'h0);
    wait_quiet();

    // Capacity one: every new key evicts the last.
    write_capacity(5'd1);
    refill_pool();
    send(lkvc_pkg::MODE_SET, key_pool[0], 32'h11);
    send(lkvc_pkg::MODE_SET, key_pool[1], 32'h22);
    send(lkvc_pkg::MODE_GET, key_pool[0], 32'h0);
    send(lkvc_pkg::MODE_GET, key_pool[1], 32'h0);
    send_random(40, 3);
    wait_quiet();

    // Zero capacity behaves as one.
    write_capacity(5'd0);
    refill_pool();
    send(lkvc_pkg::MODE_SET, key_pool[0], 32'h33);
    send(lkvc_pkg::MODE_SET, key_pool[1], 32'h44);
    send(lkvc_pkg::MODE_GET, key_pool[0], 32'h0);
    send(lkvc_pkg::MODE_GET, key_pool[1], 32'h0);
    send_random(30, 3);
    wait_quiet();

    // Capacity above the array clamps; a long run with no idling, split by a
    // sender pause that lets every response drain.
    write_capacity(5'd31);
    refill_pool();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(80, 20);
    wait_quiet();
    send_random(80, 20);
    wait_quiet();
    send_idle_pct  = 37;
    recv_stall_pct = 37;

    // Mid capacity with a long receiver hold-off while requests keep coming.
    cap = $urandom_range(15, 2);
    write_capacity(cap[lkvc_pkg::CAP_W-1:0]);
    refill_pool();
    hold_req = ~hold_req;
    send_random(120, cap + 4);
    wait_quiet();

    // Fill all entries, then drop the capacity below the count.
    write_capacity(5'd16);
    refill_pool();
    for (int i = 0; i < NUM_ENTRIES; i++) send(lkvc_pkg::MODE_SET, key_pool[i], $urandom);
    wait_quiet();
    write_capacity(5'd3);
    send(lkvc_pkg::MODE_SET, key_pool[NUM_ENTRIES], 32'h77);  // evicts just the oldest
    send(lkvc_pkg::MODE_GET, key_pool[0], 32'h0);
    send(lkvc_pkg::MODE_GET, key_pool[1], 32'h0);
    send(lkvc_pkg::MODE_GET, key_pool[NUM_ENTRIES], 32'h0);
    send_random(120, NUM_ENTRIES + 4);
    wait_quiet();

    // Random capacity, full pool.
    cap = $urandom_range(31, 1);
    write_capacity(cap[lkvc_pkg::CAP_W-1:0]);
    refill_pool();
    send_random(130, 24);
    wait_quiet();

    if (mismatches == 0 && lookups_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
